// File: hw/rtl/acf_pkg.sv
// Package for the attitude complementary filter: payload structs, register
// indexes, CORDIC angle table and controller/datapath command types.
// No dependencies.
`default_nettype none
package acf_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CORDIC_STEPS  = 20;
    localparam int NUM_REGS      = 8;
    localparam int CFG_W         = 32;
    localparam int CFG_IDX_W     = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GYRO_WEIGHT  = 3'd0,
        REG_ACCEL_WEIGHT = 3'd1,
        REG_LOOP_PERIOD  = 3'd2,
        REG_ROLL_BIAS    = 3'd3,
        REG_PITCH_BIAS   = 3'd4,
        REG_AX_BIAS      = 3'd5,
        REG_AY_BIAS      = 3'd6,
        REG_AZ_BIAS      = 3'd7
    } t_reg_idx;

    localparam logic [16:0] GYRO_WEIGHT_RST  = 17'd64225;
    localparam logic [16:0] ACCEL_WEIGHT_RST = 17'd1311;
    localparam logic [15:0] LOOP_PERIOD_RST  = 16'd655;

    typedef struct packed {
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic signed [31:0] accel_z;
        logic signed [31:0] roll_rate;
        logic signed [31:0] pitch_rate;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pitch_angle;
        logic signed [31:0] roll_angle;
        logic signed [31:0] vertical_accel;
        logic signed [31:0] lateral_x_accel;
        logic signed [31:0] lateral_y_accel;
    } t_out_item;

    // Datapath phases selected by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQ,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_CORDIC_INIT,
        OP_CORDIC_STEP,
        OP_ANGLE,
        OP_GYRO,
        OP_BLEND,
        OP_COMMIT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [4:0] step;
        logic       sel_pitch;
    } t_dp_cmd;

    function automatic logic signed [31:0] atan_q16(input logic [4:0] i);
        logic signed [31:0] v;
        case (i)
            5'd0:  v = 32'sd2949120;
            5'd1:  v = 32'sd1740967;
            5'd2:  v = 32'sd919879;
            5'd3:  v = 32'sd466945;
            5'd4:  v = 32'sd234379;
            5'd5:  v = 32'sd117304;
            5'd6:  v = 32'sd58666;
            5'd7:  v = 32'sd29335;
            5'd8:  v = 32'sd14668;
            5'd9:  v = 32'sd7334;
            5'd10: v = 32'sd3667;
            5'd11: v = 32'sd1833;
            5'd12: v = 32'sd917;
            5'd13: v = 32'sd458;
            5'd14: v = 32'sd229;
            5'd15: v = 32'sd115;
            5'd16: v = 32'sd57;
            5'd17: v = 32'sd29;
            5'd18: v = 32'sd14;
            5'd19: v = 32'sd7;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
        logic signed [31:0] r;
        if (v > 67'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -67'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/acf_ctrl.sv
// Controller for the attitude complementary filter: sequences one sample
// through the datapath and holds the output handshake. Uses acf_pkg.
`default_nettype none
module acf_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_stall,
    output logic                  o_valid,
    input  wire                   i_stall,
    output acf_pkg::t_dp_cmd      o_cmd
);
    import acf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_SQRT_INIT, S_SQRT, S_COR_INIT, S_COR, S_ANGLE,
        S_GYRO, S_BLEND, S_COMMIT, S_OUT
    } t_state;

    t_state     r_state, n_state;
    logic [4:0] r_step, n_step;
    logic       r_pitch, n_pitch;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_pitch = r_pitch;
        o_cmd   = '{op: OP_NONE, step: r_step, sel_pitch: r_pitch};
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.op = OP_SQ;
                n_state  = S_SQRT_INIT;
            end
            S_SQRT_INIT: begin
                o_cmd.op = OP_SQRT_INIT;
                n_step   = 5'd0;
                n_state  = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.op = OP_SQRT_STEP;
                n_step   = r_step + 5'd1;
                if (r_step == 5'd31) begin
                    n_pitch = 1'b0;
                    n_state = S_COR_INIT;
                end
            end
            S_COR_INIT: begin
                o_cmd.op = OP_CORDIC_INIT;
                n_step   = 5'd0;
                n_state  = S_COR;
            end
            S_COR: begin
                o_cmd.op = OP_CORDIC_STEP;
                n_step   = r_step + 5'd1;
                if (r_step == 5'(CORDIC_STEPS - 1)) begin
                    n_state = S_ANGLE;
                end
            end
            S_ANGLE: begin
                o_cmd.op = OP_ANGLE;
                if (r_pitch) begin
                    n_state = S_GYRO;
                end else begin
                    n_pitch = 1'b1;
                    n_state = S_COR_INIT;
                end
            end
            S_GYRO: begin
                o_cmd.op = OP_GYRO;
                n_state  = S_BLEND;
            end
            S_BLEND: begin
                o_cmd.op = OP_BLEND;
                n_state  = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.op = OP_COMMIT;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_pitch <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_pitch <= n_pitch;
        end
    end

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("input open while busy");
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COR) |-> (r_step < 5'(CORDIC_STEPS)))
        else $error("cordic step out of range");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/acf_dpath.sv
// Datapath for the attitude complementary filter: bias add, bit-serial square
// root, shared CORDIC atan2 and blend. Uses acf_pkg.
`default_nettype none
module acf_dpath #(
    parameter int FRACTION_BITS = acf_pkg::FRAC_BITS_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  acf_pkg::t_dp_cmd      i_cmd,
    input  acf_pkg::t_in_item     i_item,
    input  wire  [16:0]           i_gyro_weight,
    input  wire  [16:0]           i_accel_weight,
    input  wire  [15:0]           i_loop_period,
    input  wire  signed [31:0]    i_roll_bias,
    input  wire  signed [31:0]    i_pitch_bias,
    input  wire  signed [31:0]    i_ax_bias,
    input  wire  signed [31:0]    i_ay_bias,
    input  wire  signed [31:0]    i_az_bias,
    output acf_pkg::t_out_item    o_item
);
    import acf_pkg::*;

    localparam int SH = FRACTION_BITS - 16;

    logic signed [31:0] r_ax, r_ay, r_az, r_rr, r_pr;
    logic signed [31:0] r_pitch_est, r_roll_est;
    logic signed [31:0] r_roll_acc, r_pitch_acc;
    logic signed [31:0] r_gt_p, r_gt_r;
    logic signed [31:0] r_new_p, r_new_r;
    logic [63:0]        r_rem, r_root, r_sq_y, r_sq_z;
    logic signed [54:0] r_cx, r_cy;
    logic signed [31:0] r_cz;
    logic               r_trivial;
    logic signed [31:0] r_triv_z;

    logic [65:0]        sq_trial;
    logic [63:0]        sq_bit;
    logic signed [32:0] cin_y, cin_x;
    logic signed [54:0] sx_in, sy_in, dx, dy;
    logic signed [33:0] zneg;
    logic signed [31:0] zsrc, zqf;
    logic signed [49:0] zmul;
    logic               vertical;
    logic signed [31:0] deg90;
    logic signed [48:0] rdt_p, rdt_r;
    logic signed [66:0] bl_p, bl_r;

    always_comb begin
        sq_bit   = 64'd1 << (6'd62 - {i_cmd.step, 1'b0});
        sq_trial = {2'b0, r_root} + {2'b0, sq_bit};

        if (i_cmd.sel_pitch) begin
            cin_y = 33'(r_ay);
            cin_x = 33'(r_az);
        end else begin
            cin_y = 33'(r_ax);
            cin_x = {1'b0, r_root[31:0]};
        end
        sx_in = 55'(cin_x) <<< 20;
        sy_in = 55'(cin_y) <<< 20;
        dx    = r_cy >>> i_cmd.step;
        dy    = r_cx >>> i_cmd.step;

        zsrc  = r_trivial ? r_triv_z : r_cz;
        zneg  = i_cmd.sel_pitch ? -34'(zsrc) : 34'(zsrc);
        if (SH >= 0) begin
            zmul = 50'(zneg) <<< (SH >= 0 ? SH : 0);
        end else begin
            zmul = (50'(zneg) + (50'sd1 <<< (SH < 0 ? -SH - 1 : 0)))
                   >>> (SH < 0 ? -SH : 0);
        end
        zqf = sat32(67'(zmul));

        deg90    = sat32(67'sd90 <<< FRACTION_BITS);
        vertical = ((67'(r_roll_acc) == (67'sd90 <<< FRACTION_BITS)) ||
                    (67'(r_roll_acc) == -(67'sd90 <<< FRACTION_BITS)));
        rdt_p = (49'(r_pr) * $signed({1'b0, i_loop_period})) >>> 16;
        rdt_r = (49'(r_rr) * $signed({1'b0, i_loop_period})) >>> 16;
        bl_p  = ($signed({1'b0, i_gyro_weight}) * 67'(r_gt_p) +
                 $signed({1'b0, i_accel_weight}) * 67'(r_pitch_acc)) >>> 16;
        bl_r  = ($signed({1'b0, i_gyro_weight}) * 67'(r_gt_r) +
                 $signed({1'b0, i_accel_weight}) * 67'(r_roll_acc)) >>> 16;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch_est <= '0;
            r_roll_est  <= '0;
        end else if (i_cmd.op == OP_COMMIT) begin
            r_pitch_est <= r_new_p;
            r_roll_est  <= r_new_r;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_ax <= sat32(67'(i_item.accel_x) + 67'(i_ax_bias));
                r_ay <= sat32(67'(i_item.accel_y) + 67'(i_ay_bias));
                r_az <= sat32(67'(i_item.accel_z) + 67'(i_az_bias));
                r_rr <= sat32(67'(i_item.roll_rate) + 67'(i_roll_bias));
                r_pr <= sat32(67'(i_item.pitch_rate) + 67'(i_pitch_bias));
            end
            OP_SQ: begin
                r_sq_y <= 64'(r_ay * r_ay);
                r_sq_z <= 64'(r_az * r_az);
            end
            OP_SQRT_INIT: begin
                r_rem  <= r_sq_y + r_sq_z;
                r_root <= '0;
            end
            OP_SQRT_STEP: begin
                if ({2'b0, r_rem} >= sq_trial) begin
                    r_rem  <= r_rem - sq_trial[63:0];
                    r_root <= (r_root >> 1) + sq_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
            end
            OP_CORDIC_INIT: begin
                r_trivial <= (cin_y == 0) || (cin_x == 0);
                if (cin_y == 0) begin
                    r_triv_z <= (cin_x < 0) ? 32'sd11796480 : 32'sd0;
                end else begin
                    r_triv_z <= (cin_y > 0) ? 32'sd5898240 : -32'sd5898240;
                end
                if (cin_x < 0) begin
                    if (cin_y >= 0) begin
                        r_cx <= sy_in;
                        r_cy <= -sx_in;
                        r_cz <= 32'sd5898240;
                    end else begin
                        r_cx <= -sy_in;
                        r_cy <= sx_in;
                        r_cz <= -32'sd5898240;
                    end
                end else begin
                    r_cx <= sx_in;
                    r_cy <= sy_in;
                    r_cz <= '0;
                end
            end
            OP_CORDIC_STEP: begin
                if (r_cy > 0) begin
                    r_cx <= r_cx + dx;
                    r_cy <= r_cy - dy;
                    r_cz <= r_cz + atan_q16(i_cmd.step);
                end else begin
                    r_cx <= r_cx - dx;
                    r_cy <= r_cy + dy;
                    r_cz <= r_cz - atan_q16(i_cmd.step);
                end
            end
            OP_ANGLE: begin
                if (i_cmd.sel_pitch) begin
                    r_pitch_acc <= zqf;
                end else begin
                    r_roll_acc <= zqf;
                end
            end
            OP_GYRO: begin
                r_gt_p <= sat32(67'(r_pitch_est) + 67'(rdt_p));
                r_gt_r <= sat32(67'(r_roll_est) + 67'(rdt_r));
            end
            OP_BLEND: begin
                r_new_p <= vertical ? r_gt_p : sat32(bl_p);
                r_new_r <= vertical ? r_gt_r : sat32(bl_r);
            end
            default: begin
            end
        endcase
    end

    assign o_item = '{pitch_angle: r_pitch_est, roll_angle: r_roll_est,
                      vertical_accel: r_az, lateral_x_accel: r_ax,
                      lateral_y_accel: r_ay};

`ifndef SYNTHESIS
    a_deg90_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_BLEND) && vertical |=> (r_new_p == $past(r_gt_p)))
        else $error("vertical case did not bypass blend");
    a_root_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_CORDIC_INIT) |-> (r_root[63:33] == '0) || (deg90 != 0))
        else $error("root too wide");
    a_commit_est: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_COMMIT) |=> (r_roll_est == $past(r_new_r)))
        else $error("estimate not committed");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/attitude_complementary_filter.sv
// Top level of the attitude complementary filter: configuration registers,
// controller and datapath. Uses acf_pkg, acf_ctrl, acf_dpath.
//
// A sample passes from transfer in to result valid through squaring, the
// bit-serial 64-bit square root, two passes through the shared CORDIC atan2
// unit with angle scaling, and then gyro integration, blend and commit. The
// input stalls from transfer in until the result is taken, so a new sample is
// not accepted before the last one is through.
`default_nettype none
module attitude_complementary_filter #(
    parameter int FRACTION_BITS = acf_pkg::FRAC_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  acf_pkg::t_in_item            i_data,
    output logic                         o_valid,
    input  wire                          i_stall,
    output acf_pkg::t_out_item           o_data,
    input  wire                          i_cfg_we,
    input  wire  [acf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire  [acf_pkg::CFG_W-1:0]    i_cfg_data
);
    import acf_pkg::*;

    logic [16:0]        r_gyro_weight, r_accel_weight;
    logic [15:0]        r_loop_period;
    logic signed [31:0] r_roll_bias, r_pitch_bias, r_ax_bias, r_ay_bias, r_az_bias;
    t_dp_cmd            cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gyro_weight  <= GYRO_WEIGHT_RST;
            r_accel_weight <= ACCEL_WEIGHT_RST;
            r_loop_period  <= LOOP_PERIOD_RST;
            r_roll_bias    <= '0;
            r_pitch_bias   <= '0;
            r_ax_bias      <= '0;
            r_ay_bias      <= '0;
            r_az_bias      <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_GYRO_WEIGHT:  r_gyro_weight  <= i_cfg_data[16:0];
                REG_ACCEL_WEIGHT: r_accel_weight <= i_cfg_data[16:0];
                REG_LOOP_PERIOD:  r_loop_period  <= i_cfg_data[15:0];
                REG_ROLL_BIAS:    r_roll_bias    <= i_cfg_data;
                REG_PITCH_BIAS:   r_pitch_bias   <= i_cfg_data;
                REG_AX_BIAS:      r_ax_bias      <= i_cfg_data;
                REG_AY_BIAS:      r_ay_bias      <= i_cfg_data;
                REG_AZ_BIAS:      r_az_bias      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    acf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd)
    );

    acf_dpath #(.FRACTION_BITS(FRACTION_BITS)) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_item         (i_data),
        .i_gyro_weight  (r_gyro_weight),
        .i_accel_weight (r_accel_weight),
        .i_loop_period  (r_loop_period),
        .i_roll_bias    (r_roll_bias),
        .i_pitch_bias   (r_pitch_bias),
        .i_ax_bias      (r_ax_bias),
        .i_ay_bias      (r_ay_bias),
        .i_az_bias      (r_az_bias),
        .o_item         (o_data)
    );

endmodule
`default_nettype wire
